// ===== design/gf256_aes_arithmetic_unit_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the GF(2^8) arithmetic unit.
// ---------------------------------------------------------------------------
`ifndef GF256_AES_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define GF256_AES_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAAU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gaau_pkg.sv =====
// ---------------------------------------------------------------------------
// gaau_pkg
// Operation codes, field constants and helper functions of the GF(2^8) unit.
// ---------------------------------------------------------------------------
`default_nettype none

package gaau_pkg;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_XTIME  = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_INV    = 3'd3;
    localparam logic [2:0] OP_SBOX   = 3'd4;
    localparam logic [2:0] OP_INVSBX = 3'd5;
    localparam logic [2:0] OP_EXP    = 3'd6;
    localparam logic [2:0] OP_LOG    = 3'd7;

    localparam logic [7:0] FIELD_REDUCE     = 8'h1b;
    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] AFFINE_INV_CONST = 8'h05;
    // Multiplicative group order; also the largest log value.
    localparam logic [7:0] GROUP_ORDER      = 8'd255;
    localparam logic [7:0] LAST_POWER       = 8'd254;

    localparam int TABLE_DEPTH = 256;
    localparam int BYTE_W      = 8;

    // One write of the table fill sequencer: element = 3^power_idx.
    typedef struct packed {
        logic       busy;
        logic [7:0] power_idx;
        logic [7:0] elem;
    } fill_wr_t;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? FIELD_REDUCE : 8'h00);
    endfunction

    // Carry-less product reduced mod 0x11b; flattens to an AND-XOR network.
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] term;
        acc  = 8'h00;
        term = y;
        for (int k = 0; k < 8; k++)
        begin
            if (x[k])
            begin
                acc = acc ^ term;
            end
            term = xtime(term);
        end
        gf_mul = acc;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
        rotl = 8'((v << n) | (v >> (8 - n)));
    endfunction

    function automatic logic [7:0] affine_fwd(input logic [7:0] v);
        affine_fwd = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ AFFINE_CONST;
    endfunction

    function automatic logic [7:0] affine_back(input logic [7:0] v);
        affine_back = rotl(v, 1) ^ rotl(v, 3) ^ rotl(v, 6) ^ AFFINE_INV_CONST;
    endfunction

endpackage

`default_nettype wire

// ===== design/gf256_aes_arithmetic_unit_core.sv =====
// ---------------------------------------------------------------------------
// gf256_aes_arithmetic_unit_core
// Byte arithmetic over GF(2^8) mod 0x11b built around exp and log memories.
// ---------------------------------------------------------------------------
// Usage:
// One word enters on s_axis per operation: an operation code and two bytes.
// Each word yields exactly one result byte on m_axis, in order.
// Inverse, S-box and inverse S-box go through a log then an exp lookup;
// exp and log use one memory each; add, xtime and multiply are computed
// directly in logic.
// A result word passes the stage 1 log read, the stage 2 exp read and the
// output register before it is valid on m_axis.
// Throughput is one word per cycle while results are taken: the two memory
// read stages and the output register all advance together unless stalled.
// After reset a fill sequencer writes the generator powers into the tables;
// s_axis_tready stays low until it is done.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// in the same cycle; the held result word stays unchanged until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module gf256_aes_arithmetic_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] operation, [10:3] operand_a, [18:11] operand_b, [23:19] zero
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] result_byte
    output logic      [7:0]  m_axis_tdata
);

    gaau_pkg::fill_wr_t fill;

    logic       adv;
    logic       accept;
    logic [2:0] in_op;
    logic [7:0] in_a;
    logic [7:0] in_b;
    logic [7:0] log_addr_a;

    // Stage 1: log lookup in flight.
    logic       v1_reg;
    logic [2:0] op1_reg;
    logic [7:0] a1_reg;
    logic [7:0] b1_reg;
    logic       za1_reg;
    logic [7:0] log_a;

    // Stage 2: exp lookup in flight.
    logic       v2_reg;
    logic [2:0] op2_reg;
    logic       zero2_reg;
    logic [7:0] res2_reg;
    logic [7:0] exp_addr;
    logic       zero2_next;
    logic [7:0] res2_next;
    logic [7:0] exp_val;

    logic       out_valid_reg;
    logic [7:0] out_data_reg, out_data_next;
    logic [7:0] inv_val;

    assign in_op = s_axis_tdata[2:0];
    assign in_a  = s_axis_tdata[10:3];
    assign in_b  = s_axis_tdata[18:11];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv && !fill.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The inverse S-box undoes the affine map before taking the inverse.
    assign log_addr_a = (in_op == gaau_pkg::OP_INVSBX) ? gaau_pkg::affine_back(in_a) : in_a;

    gaau_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fill)
    );

    gaau_ram #(.DATA_W(gaau_pkg::BYTE_W), .DEPTH(gaau_pkg::TABLE_DEPTH)) u_log_a (
        .clk   (clk),
        .we    (fill.busy),
        .waddr (fill.elem),
        .wdata (fill.power_idx),
        .re    (adv),
        .raddr (log_addr_a),
        .rdata (log_a)
    );

    gaau_ram #(.DATA_W(gaau_pkg::BYTE_W), .DEPTH(gaau_pkg::TABLE_DEPTH)) u_exp (
        .clk   (clk),
        .we    (fill.busy),
        .waddr (fill.power_idx),
        .wdata (fill.elem),
        .re    (adv),
        .raddr (exp_addr),
        .rdata (exp_val)
    );

    // Stage 1 logic: the exp address for inversion and exp, and the direct and log results.
    // Log entries hold 0 for the element 1, whose inverse is 3^0.
    always_comb
    begin
        exp_addr   = 8'd0;
        zero2_next = 1'b0;
        res2_next  = 8'd0;
        case (op1_reg)
            gaau_pkg::OP_ADD:
            begin
                res2_next = a1_reg ^ b1_reg;
            end
            gaau_pkg::OP_XTIME:
            begin
                res2_next = gaau_pkg::xtime(a1_reg);
            end
            gaau_pkg::OP_MUL:
            begin
                res2_next = gaau_pkg::gf_mul(a1_reg, b1_reg);
            end
            gaau_pkg::OP_INV, gaau_pkg::OP_SBOX, gaau_pkg::OP_INVSBX:
            begin
                exp_addr   = (log_a == 8'd0) ? 8'd0 : gaau_pkg::GROUP_ORDER - log_a;
                zero2_next = za1_reg;
            end
            gaau_pkg::OP_EXP:
            begin
                // 3^255 equals 3^0.
                exp_addr = (a1_reg == gaau_pkg::GROUP_ORDER) ? 8'd0 : a1_reg;
            end
            default:
            begin
                // Log of zero is zero; log of one is reported as 255.
                if (za1_reg)
                begin
                    res2_next = 8'd0;
                end
                else if (log_a == 8'd0)
                begin
                    res2_next = gaau_pkg::GROUP_ORDER;
                end
                else
                begin
                    res2_next = log_a;
                end
            end
        endcase
    end

    // Stage 2 logic: pick the exp lookup or the direct result, applying the affine map for the S-box.
    always_comb
    begin
        inv_val = zero2_reg ? 8'd0 : exp_val;
        case (op2_reg)
            gaau_pkg::OP_ADD, gaau_pkg::OP_XTIME, gaau_pkg::OP_MUL, gaau_pkg::OP_LOG:
            begin
                out_data_next = res2_reg;
            end
            gaau_pkg::OP_SBOX:
            begin
                out_data_next = gaau_pkg::affine_fwd(inv_val);
            end
            gaau_pkg::OP_EXP:
            begin
                out_data_next = exp_val;
            end
            default:
            begin
                out_data_next = inv_val;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg      <= in_op;
            a1_reg       <= in_a;
            b1_reg       <= in_b;
            za1_reg      <= (log_addr_a == 8'd0);
            op2_reg      <= op1_reg;
            zero2_reg    <= zero2_next;
            res2_reg     <= res2_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/gaau_ram.sv =====
// ---------------------------------------------------------------------------
// gaau_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module gaau_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gaau_fill.sv =====
// ---------------------------------------------------------------------------
// gaau_fill
// After reset, walks the powers of the generator 3 and emits one table write
// per cycle for the exp and log memories.
// ---------------------------------------------------------------------------
`default_nettype none

module gaau_fill (
    input  wire logic           clk,
    input  wire logic           rst_n,
    output gaau_pkg::fill_wr_t  wr
);

    logic       busy_reg, busy_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] pow_reg, pow_next;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        pow_next  = pow_reg;
        if (busy_reg)
        begin
            // Multiply by 3: p * 2 + p.
            pow_next = gaau_pkg::xtime(pow_reg) ^ pow_reg;
            idx_next = idx_reg + 8'd1;
            if (idx_reg == gaau_pkg::LAST_POWER)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 8'd0;
            pow_reg  <= 8'd1;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            pow_reg  <= pow_next;
        end
    end

    assign wr.busy      = busy_reg;
    assign wr.power_idx = idx_reg;
    assign wr.elem      = pow_reg;

endmodule

`default_nettype wire

// ===== design/gaau_checker.sv =====
// ---------------------------------------------------------------------------
// gaau_checker
// Port-level checks of the GF(2^8) arithmetic unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gf256_aes_arithmetic_unit_core_assert.svh"

module gaau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [23:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    // The input side opens only when the held result can move.
    `GAAU_ASSERT_IMPLY(a_ready_needs_room, clk, rst_n, s_axis_tready, !m_axis_tvalid || m_axis_tready, "input ready while output is stalled")

    // A stalled result word keeps its data.
    `GAAU_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // With the receiver ready, a result follows acceptance through the stage 1, stage 2 and output registers.
    `GAAU_ASSERT_NEXT(a_latency, clk, rst_n, (s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready), m_axis_tvalid, "result missing after three cycles")

    // An add word yields the XOR of its operands.
    `GAAU_ASSERT_NEXT(a_add_value, clk, rst_n, (s_axis_tvalid && s_axis_tready && s_axis_tdata[2:0] == gaau_pkg::OP_ADD && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready), m_axis_tdata == $past(s_axis_tdata[10:3] ^ s_axis_tdata[18:11], 3), "add result wrong")

endmodule

bind gf256_aes_arithmetic_unit_core gaau_checker u_gaau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/gf256_aes_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gf256_aes_arithmetic_unit_core_tb
// Self-checking bench for the GF(2^8) byte unit. Operation words are streamed
// in and each result byte is compared with an independent bit-level predictor.
// Directed corner cases come first, then random words under changing
// sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module gf256_aes_arithmetic_unit_core_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_WORDS   = 160;

    typedef struct {
        logic [2:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] result;
    } pending_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] operation, [10:3] operand_a, [18:11] operand_b, [23:19] zero
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] result_byte
    logic [7:0]  m_axis_tdata;

    pending_byte_t pending_bytes[$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;

    gf256_aes_arithmetic_unit_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic logic [7:0] mul2(input logic [7:0] v);
        logic [8:0] wide;
        begin
            wide = {v, 1'b0};
            if (wide[8])
                wide[7:0] = wide[7:0] ^ gaau_pkg::FIELD_REDUCE;
            return wide[7:0];
        end
    endfunction

    // Shift-and-add multiply: one partial product per bit of x.
    function automatic logic [7:0] gf_mult(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] sum;
        logic [7:0] term;
        begin
            sum = 8'h00;
            term = y;
            for (int i = 0; i < 8; i++)
            begin
                if (x[i])
                    sum = sum ^ term;
                term = mul2(term);
            end
            return sum;
        end
    endfunction

    // Three raised to e by repeated multiplication; e = 255 wraps back to 1.
    function automatic logic [7:0] gf_exp_of(input logic [7:0] e);
        logic [7:0] p;
        begin
            p = 8'h01;
            for (int i = 0; i < e; i++)
                p = gf_mult(p, 8'h03);
            return p;
        end
    endfunction

    function automatic logic [7:0] gf_log_of(input logic [7:0] v);
        logic [7:0] p;
        begin
            if (v == 8'h00)
                return 8'h00;
            if (v == 8'h01)
                return gaau_pkg::GROUP_ORDER;
            p = 8'h03;
            for (int i = 1; i < 255; i++)
            begin
                if (p == v)
                    return 8'(i);
                p = gf_mult(p, 8'h03);
            end
            return 8'h00;
        end
    endfunction

    // Brute-force search for the partner whose product is one.
    function automatic logic [7:0] gf_inverse(input logic [7:0] v);
        begin
            if (v == 8'h00)
                return 8'h00;
            for (int c = 1; c < 256; c++)
                if (gf_mult(v, 8'(c)) == 8'h01)
                    return 8'(c);
            return 8'h00;
        end
    endfunction

    function automatic logic [7:0] rot_left(input logic [7:0] v, input int n);
        logic [15:0] twice;
        begin
            twice = {v, v};
            return twice[15 - n -: 8];
        end
    endfunction

    function automatic logic [7:0] fwd_affine_map(input logic [7:0] v);
        return v ^ rot_left(v, 1) ^ rot_left(v, 2) ^ rot_left(v, 3)
                 ^ rot_left(v, 4) ^ gaau_pkg::AFFINE_CONST;
    endfunction

    function automatic logic [7:0] back_affine_map(input logic [7:0] v);
        return rot_left(v, 1) ^ rot_left(v, 3) ^ rot_left(v, 6)
                 ^ gaau_pkg::AFFINE_INV_CONST;
    endfunction

    function automatic logic [7:0] expected_byte(input logic [2:0] op,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b);
        case (op)
            gaau_pkg::OP_ADD:    return a ^ b;
            gaau_pkg::OP_XTIME:  return mul2(a);
            gaau_pkg::OP_MUL:    return gf_mult(a, b);
            gaau_pkg::OP_INV:    return gf_inverse(a);
            gaau_pkg::OP_SBOX:   return fwd_affine_map(gf_inverse(a));
            gaau_pkg::OP_INVSBX: return gf_inverse(back_affine_map(a));
            gaau_pkg::OP_EXP:    return gf_exp_of(a);
            default:             return gf_log_of(a);
        endcase
    endfunction

    // ---------------- driving ----------------

    task automatic send_word(input logic [2:0] op, input logic [7:0] a, input logic [7:0] b);
        pending_byte_t entry;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {5'b0, b, a, op};
            do
                @(posedge clk);
            while (!s_axis_tready);
            entry.op = op;
            entry.a = a;
            entry.b = b;
            entry.result = expected_byte(op, a, b);
            pending_bytes = {pending_bytes, entry};
        end
    endtask

    // Mostly uniform bytes, with the field's special elements mixed in often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hff;
            3:       return 8'h80;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_words(input int count);
        begin
            for (int i = 0; i < count; i++)
                send_word(3'($urandom_range(7)), pick_byte(), pick_byte());
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input pending_byte_t entry,
                                   input logic [7:0] got);
        begin
            $display("ERROR %0t: %s op=%0d a=%02h b=%02h expected=%02h got=%02h",
                     $realtime, what, entry.op, entry.a, entry.b, entry.result, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pending_byte_t entry;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                entry = '{op: 3'd0, a: 8'h00, b: 8'h00, result: 8'h00};
                report_mismatch("result word with nothing pending", entry, m_axis_tdata);
            end
            else
            begin
                entry = pending_bytes.pop_front();
                if (m_axis_tdata !== entry.result)
                    report_mismatch("result_byte mismatch", entry, m_axis_tdata);
            end
        end
    end

    // Ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------

    // Field extremes, every operation and the documented special cases.
    // Operand b carries noise on the operations that must ignore it.
    task automatic test_special_values();
        begin
            send_word(gaau_pkg::OP_ADD, 8'h00, 8'h00);
            send_word(gaau_pkg::OP_ADD, 8'hff, 8'hff);
            send_word(gaau_pkg::OP_ADD, 8'haa, 8'h55);
            send_word(gaau_pkg::OP_XTIME, 8'h80, 8'hff);
            send_word(gaau_pkg::OP_XTIME, 8'hff, 8'h5a);
            send_word(gaau_pkg::OP_XTIME, 8'h7f, 8'h00);
            send_word(gaau_pkg::OP_MUL, 8'h57, 8'h83);
            send_word(gaau_pkg::OP_MUL, 8'hff, 8'hff);
            send_word(gaau_pkg::OP_MUL, 8'h00, 8'hc3);
            send_word(gaau_pkg::OP_MUL, 8'h01, 8'h9e);
            send_word(gaau_pkg::OP_INV, 8'h00, 8'hff);
            send_word(gaau_pkg::OP_INV, 8'h01, 8'h00);
            send_word(gaau_pkg::OP_INV, 8'hff, 8'ha5);
            send_word(gaau_pkg::OP_SBOX, 8'h00, 8'h3c);
            send_word(gaau_pkg::OP_SBOX, 8'hff, 8'hff);
            send_word(gaau_pkg::OP_INVSBX, 8'h63, 8'h81);
            send_word(gaau_pkg::OP_INVSBX, 8'h00, 8'h00);
            send_word(gaau_pkg::OP_INVSBX, 8'hff, 8'h7e);
            send_word(gaau_pkg::OP_EXP, 8'h00, 8'hff);
            send_word(gaau_pkg::OP_EXP, 8'hff, 8'h00);
            send_word(gaau_pkg::OP_EXP, 8'h01, 8'h42);
            send_word(gaau_pkg::OP_LOG, 8'h00, 8'hff);
            send_word(gaau_pkg::OP_LOG, 8'h01, 8'h18);
            send_word(gaau_pkg::OP_LOG, 8'h03, 8'h00);
            send_word(gaau_pkg::OP_LOG, 8'hff, 8'he7);
        end
    endtask

    task automatic test_back_to_back();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
            send_random_words(RANDOM_WORDS);
        end
    endtask

    task automatic test_sender_gaps();
        begin
            send_idle_pct = 87;
            recv_stall_pct = 0;
            send_random_words(RANDOM_WORDS);
        end
    endtask

    task automatic test_receiver_stalls();
        begin
            send_idle_pct = 0;
            recv_stall_pct = 87;
            send_random_words(RANDOM_WORDS);
        end
    endtask

    task automatic test_light_idling();
        begin
            send_idle_pct = 6;
            recv_stall_pct = 6;
            send_random_words(RANDOM_WORDS);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_values();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_light_idling();

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
